// File: src/accel_tilt_angles_defines.svh
// ----------------------------------------------------------------------------
// accel_tilt_angles_defines
// assertion macros shared by the tilt angle block
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ATILT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ATILT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ATILT_ASSERT(lbl, prop, msg)
`define ATILT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: src/atilt_pkg.sv
// ----------------------------------------------------------------------------
// atilt_pkg
// widths, constants and helpers for the tilt angle datapath
// ----------------------------------------------------------------------------
package atilt_pkg;

    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 8;

    localparam int IN_W   = 16;
    localparam int OUT_W  = 16;
    localparam int SQ_W   = 32;                       // a*a + b*b
    localparam int N_W    = 62;                       // radicand, sum shifted up by 30
    localparam int M_W    = 31;                       // root width, one stage per bit
    localparam int REM_W  = 34;
    localparam int V_W    = 35;                       // cordic vector width
    localparam int ACC_W  = 33;                       // angle accumulator, 2^-24 degree
    localparam int TBL_LEN = 24;
    localparam int NSTEP  = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
    localparam int SHIFT  = 24 - ANGLE_FRACTION_BITS;
    localparam int C_W    = ACC_W + 2 - SHIFT;        // clamped angle width
    localparam int LIM    = 90 << ANGLE_FRACTION_BITS;
    localparam int LIM_SAT = (LIM > 32767) ? 32767 : LIM;
    localparam logic signed [OUT_W-1:0] LIM_OUT = OUT_W'(LIM_SAT);

    // atan(2^-i) in degrees scaled by 2^24
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 33'sd754974720;
            1:  v = 33'sd445687602;
            2:  v = 33'sd235489088;
            3:  v = 33'sd119537938;
            4:  v = 33'sd60000934;
            5:  v = 33'sd30029717;
            6:  v = 33'sd15018523;
            7:  v = 33'sd7509720;
            8:  v = 33'sd3754917;
            9:  v = 33'sd1877466;
            10: v = 33'sd938734;
            11: v = 33'sd469367;
            12: v = 33'sd234684;
            13: v = 33'sd117342;
            14: v = 33'sd58671;
            15: v = 33'sd29335;
            16: v = 33'sd14668;
            17: v = 33'sd7334;
            18: v = 33'sd3667;
            19: v = 33'sd1833;
            20: v = 33'sd917;
            21: v = 33'sd458;
            22: v = 33'sd229;
            23: v = 33'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [C_W:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > (C_W+1)'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -(C_W+1)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/atilt_sqrt.sv
// ----------------------------------------------------------------------------
// atilt_sqrt
// squares two axes and takes floor(sqrt(sum * 2^30)), one root bit per stage
// ----------------------------------------------------------------------------
module atilt_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [atilt_pkg::IN_W-1:0]   i_a,
    input  logic signed [atilt_pkg::IN_W-1:0]   i_b,
    input  logic signed [atilt_pkg::IN_W-1:0]   i_num,
    output logic                                o_valid,
    output logic        [atilt_pkg::M_W-1:0]    o_mag,
    output logic signed [atilt_pkg::IN_W-1:0]   o_num
);
    localparam int IW = atilt_pkg::IN_W;
    localparam int MW = atilt_pkg::M_W;
    localparam int NW = atilt_pkg::N_W;
    localparam int RW = atilt_pkg::REM_W;
    localparam int SW = atilt_pkg::SQ_W;

    logic                 r_v_sq;
    logic [SW-2:0]        r_aa, r_bb;
    logic signed [IW-1:0] r_num_sq;
    logic                 r_v_sum;
    logic [SW-1:0]        r_sum;
    logic signed [IW-1:0] r_num_sum;

    logic                 r_v   [MW];
    logic [NW-1:0]        r_n   [MW];
    logic [RW-1:0]        r_rem [MW];
    logic [MW-1:0]        r_res [MW];
    logic signed [IW-1:0] r_num [MW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sq  <= 1'b0;
            r_v_sum <= 1'b0;
        end else if (i_en) begin
            r_v_sq  <= i_valid;
            r_v_sum <= r_v_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa      <= (SW-1)'($unsigned((2*IW)'(i_a) * (2*IW)'(i_a)));
            r_bb      <= (SW-1)'($unsigned((2*IW)'(i_b) * (2*IW)'(i_b)));
            r_num_sq  <= i_num;
            r_sum     <= {1'b0, r_aa} + {1'b0, r_bb};
            r_num_sum <= r_num_sq;
        end
    end

    genvar j;
    generate
        for (j = 0; j < MW; j++) begin : g_root
            logic                 v_in;
            logic [NW-1:0]        n_in;
            logic [RW-1:0]        rem_in, rem_sh, trial;
            logic [MW-1:0]        res_in;
            logic signed [IW-1:0] num_in;
            if (j == 0) begin : g_first
                assign v_in   = r_v_sum;
                assign n_in   = {r_sum, (NW-SW)'(0)};
                assign rem_in = '0;
                assign res_in = '0;
                assign num_in = r_num_sum;
            end else begin : g_next
                assign v_in   = r_v[j-1];
                assign n_in   = r_n[j-1];
                assign rem_in = r_rem[j-1];
                assign res_in = r_res[j-1];
                assign num_in = r_num[j-1];
            end
            assign rem_sh = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
            assign trial  = RW'({res_in, 2'b01});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[j]   <= {n_in[NW-3:0], 2'b00};
                    r_num[j] <= num_in;
                    if (rem_sh >= trial) begin
                        r_rem[j] <= rem_sh - trial;
                        r_res[j] <= {res_in[MW-2:0], 1'b1};
                    end else begin
                        r_rem[j] <= rem_sh;
                        r_res[j] <= {res_in[MW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[MW-1];
    assign o_mag   = r_res[MW-1];
    assign o_num   = r_num[MW-1];

endmodule

// File: src/atilt_cordic.sv
// ----------------------------------------------------------------------------
// atilt_cordic
// vectoring cordic, one micro-rotation per stage, angle in 2^-24 degree
// ----------------------------------------------------------------------------
module atilt_cordic (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic        [atilt_pkg::M_W-1:0]    i_mag,
    input  logic signed [atilt_pkg::IN_W-1:0]   i_num,
    output logic                                o_valid,
    output logic                                o_zero,
    output logic signed [atilt_pkg::ACC_W-1:0]  o_angle
);
    localparam int NS = atilt_pkg::NSTEP;
    localparam int VW = atilt_pkg::V_W;
    localparam int AW = atilt_pkg::ACC_W;
    localparam int MW = atilt_pkg::M_W;
    localparam int IW = atilt_pkg::IN_W;

    logic                 r_v    [NS];
    logic                 r_zero [NS];
    logic signed [VW-1:0] r_vx   [NS];
    logic signed [VW-1:0] r_vy   [NS];
    logic signed [AW-1:0] r_acc  [NS];

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_rot
            logic                 v_in, zero_in;
            logic signed [VW-1:0] vx_in, vy_in, dx, dy;
            logic signed [AW-1:0] acc_in;
            if (i == 0) begin : g_first
                assign v_in    = i_valid;
                assign zero_in = (i_num == '0) && (i_mag == '0);
                assign vx_in   = $signed({(VW-MW)'(0), i_mag});
                assign vy_in   = $signed({{(VW-IW-15){i_num[IW-1]}}, i_num, 15'b0});
                assign acc_in  = '0;
            end else begin : g_next
                assign v_in    = r_v[i-1];
                assign zero_in = r_zero[i-1];
                assign vx_in   = r_vx[i-1];
                assign vy_in   = r_vy[i-1];
                assign acc_in  = r_acc[i-1];
            end
            assign dx = vy_in >>> i;
            assign dy = vx_in >>> i;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[i] <= 1'b0;
                end else if (i_en) begin
                    r_v[i] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[i] <= zero_in;
                    if (!vy_in[VW-1]) begin
                        r_vx[i]  <= vx_in + dx;
                        r_vy[i]  <= vy_in - dy;
                        r_acc[i] <= acc_in + atilt_pkg::atan_entry(i);
                    end else begin
                        r_vx[i]  <= vx_in - dx;
                        r_vy[i]  <= vy_in + dy;
                        r_acc[i] <= acc_in - atilt_pkg::atan_entry(i);
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS-1];
    assign o_zero  = r_zero[NS-1];
    assign o_angle = r_acc[NS-1];

endmodule

// File: src/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// two tilt angles per accelerometer sample, pipelined root and cordic lanes
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (low bit up)
//  s side    in   accel_x[15:0] accel_y[31:16] accel_z[47:32]
//  m side    out  tilt_about_x[15:0] tilt_about_y[31:16]
//
//  one sample per clock unless a held result stalls the pipe; stages: 2 square/sum,
//  31 root bits, 16 cordic rotations, round/clamp, output register
//  the root stage, one bit per stage, sets the depth
//  reset clears the valid bits only; a stalled output freezes the whole pipe
//  once its last stage holds a result, bubbles still drain forward
// ----------------------------------------------------------------------------
`include "accel_tilt_angles_defines.svh"

module accel_tilt_angles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // accel_x, accel_y, accel_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // tilt_about_x, tilt_about_y
);
    localparam int IW = atilt_pkg::IN_W;
    localparam int AW = atilt_pkg::ACC_W;
    localparam int CW = atilt_pkg::C_W;
    localparam int SH = atilt_pkg::SHIFT;

    logic signed [IW-1:0] ax, ay, az;
    logic pipe_en, out_take;

    logic                 vx_sq, vy_sq;
    logic [atilt_pkg::M_W-1:0] mag_x, mag_y;
    logic signed [IW-1:0] num_x, num_y;
    logic                 vx_c, vy_c, zx, zy;
    logic signed [AW-1:0] ang_x, ang_y;

    logic                 r_v_rnd;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                 r_m_valid;
    logic [31:0]          r_m_data;
    logic                 rng_x, rng_y;

    assign ax = i_s_tdata[15:0];
    assign ay = i_s_tdata[31:16];
    assign az = i_s_tdata[47:32];

    assign out_take   = !r_m_valid || i_m_tready;
    assign pipe_en    = !r_v_rnd || out_take;
    assign o_s_tready = pipe_en;

    atilt_sqrt u_sqrt_x (
        .i_clk, .i_rst_n, .i_en(pipe_en), .i_valid(i_s_tvalid),
        .i_a(ax), .i_b(az), .i_num(ay),
        .o_valid(vx_sq), .o_mag(mag_x), .o_num(num_x)
    );

    atilt_sqrt u_sqrt_y (
        .i_clk, .i_rst_n, .i_en(pipe_en), .i_valid(i_s_tvalid),
        .i_a(ay), .i_b(az), .i_num(ax),
        .o_valid(vy_sq), .o_mag(mag_y), .o_num(num_y)
    );

    atilt_cordic u_cordic_x (
        .i_clk, .i_rst_n, .i_en(pipe_en), .i_valid(vx_sq),
        .i_mag(mag_x), .i_num(num_x),
        .o_valid(vx_c), .o_zero(zx), .o_angle(ang_x)
    );

    atilt_cordic u_cordic_y (
        .i_clk, .i_rst_n, .i_en(pipe_en), .i_valid(vy_sq),
        .i_mag(mag_y), .i_num(num_y),
        .o_valid(vy_c), .o_zero(zy), .o_angle(ang_y)
    );

    // round to nearest, ties up, then clamp to +-90 degrees
    function automatic logic signed [CW-1:0] round_clamp(input logic signed [AW-1:0] a,
                                                         input logic zero);
        logic signed [AW:0]   s;
        logic signed [AW:0]   r;
        logic signed [CW-1:0] c;
        s = zero ? '0 : ($signed({a[AW-1], a}) + $signed((AW+1)'(1) << (SH-1)));
        r = s >>> SH;
        if (r > (AW+1)'(atilt_pkg::LIM)) begin
            c = CW'(atilt_pkg::LIM);
        end else if (r < -(AW+1)'(atilt_pkg::LIM)) begin
            c = -CW'(atilt_pkg::LIM);
        end else begin
            c = r[CW-1:0];
        end
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_rnd <= 1'b0;
        end else if (pipe_en) begin
            r_v_rnd <= vx_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_cx <= round_clamp(ang_x, zx);
            r_cy <= round_clamp(ang_y, zy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_take) begin
            r_m_valid <= r_v_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_v_rnd) begin
            r_m_data <= {atilt_pkg::sat16(-$signed({r_cy[CW-1], r_cy})),
                         atilt_pkg::sat16($signed({r_cx[CW-1], r_cx}))};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign rng_x = ($signed(o_m_tdata[15:0]) <= atilt_pkg::LIM_OUT) &&
                   ($signed(o_m_tdata[15:0]) >= -atilt_pkg::LIM_OUT);
    assign rng_y = ($signed(o_m_tdata[31:16]) <= atilt_pkg::LIM_OUT) &&
                   ($signed(o_m_tdata[31:16]) >= -atilt_pkg::LIM_OUT);

    // lanes run in lockstep
    `ATILT_ASSERT(a_lane_sync, (vx_sq == vy_sq) && (vx_c == vy_c), "tilt lanes out of step")
    // the input side only waits on a held result
    `ATILT_ASSERT(a_stall_cause, !o_s_tready |-> (o_m_tvalid && !i_m_tready), "bad stall")
    // results stay within the tilt range
    `ATILT_ASSERT(a_range, o_m_tvalid |-> (rng_x && rng_y), "tilt out of range")
    `ATILT_ASSERT_RST(a_reset, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

// File: test/tb_accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles
// streams accelerometer samples through the tilt block, compares each angle pair
// with a bit-exact root and cordic predictor, under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_accel_tilt_angles;

    localparam int LATENCY   = 51;
    localparam int MAX_CYCLE = 400000;
    localparam int HOLD_LEN  = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // accel_x, accel_y, accel_z
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // tilt_about_x, tilt_about_y

    typedef struct packed {
        logic signed [15:0] tilt_y;
        logic signed [15:0] tilt_x;
    } t_angles;

    t_angles angles_q[$];
    int      n_err = 0;
    int      n_sent;
    int      n_got = 0;
    int      cycle = 0;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_req = 0;
    int      hold_ack = 0;
    int      hold_left = 0;

    accel_tilt_angles u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // exact floor square root
    function automatic longint unsigned root64(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint tilt_of(input longint num, input longint a, input longint b);
        longint unsigned sq;
        longint vx, vy, acc, dx, dy, r, lim, step_atan;
        int sh;
        sq  = longint'(a * a) + longint'(b * b);
        vx  = longint'(root64(sq << 30));
        vy  = num * 32768;
        acc = 0;
        sh  = 24 - atilt_pkg::ANGLE_FRACTION_BITS;
        lim = longint'(90) << atilt_pkg::ANGLE_FRACTION_BITS;
        if (num == 0 && vx == 0) return 0;
        for (int i = 0; i < atilt_pkg::CORDIC_STEPS && i < atilt_pkg::TBL_LEN; i++) begin
            step_atan = longint'(atilt_pkg::atan_entry(i));
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  += dx;
                vy  -= dy;
                acc += step_atan;
            end else begin
                vx  -= dx;
                vy  += dy;
                acc -= step_atan;
            end
        end
        r = (acc + (longint'(1) << (sh - 1))) >>> sh;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic t_angles predict_angles(input logic signed [15:0] ax,
                                               input logic signed [15:0] ay,
                                               input logic signed [15:0] az);
        t_angles r;
        r.tilt_x = clip16(tilt_of(ay, ax, az));
        r.tilt_y = clip16(-tilt_of(ax, ay, az));
        return r;
    endfunction

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {az, ay, ax};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        angles_q.push_back(predict_angles(ax, ay, az));
        n_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (angles_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(8)) - 16'd4;
            3: return 16'($urandom_range(512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] v[6];
        v = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h4000};
        send_sample(16'h0000, 16'h0000, 16'h0000);   // all-zero sample
        send_sample(16'h0000, 16'h0000, 16'h4000);   // level
        send_sample(16'h0000, 16'h7fff, 16'h0000);   // zero magnitude for tilt x
        send_sample(16'h8000, 16'h0000, 16'h0000);   // zero magnitude for tilt y
        send_sample(16'h0001, 16'hffff, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        for (int i = 0; i < 6; i++)
            send_sample(v[i], v[(i + 2) % 6], v[(i + 4) % 6]);
        send_sample(16'haaaa, 16'h5555, 16'hffff);
        send_sample(16'h5555, 16'haaaa, 16'h0000);
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_sample(rand_axis(), rand_axis(), rand_axis());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = hold_req + 1;
        repeat (120) send_sample(rand_axis(), rand_axis(), rand_axis());
        wait_drained();
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            hold_left  <= HOLD_LEN - 1;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles want;
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout at %0t", $time);
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            n_got++;
            if (angles_q.size() == 0) begin
                $display("%0t: unexpected transaction %h", $time, o_m_tdata);
                n_err++;
            end else begin
                want = angles_q.pop_front();
                if (got.tilt_x !== want.tilt_x) begin
                    $display("%0t: tilt_about_x expected %0d actual %0d",
                             $time, want.tilt_x, got.tilt_x);
                    n_err++;
                end
                if (got.tilt_y !== want.tilt_y) begin
                    $display("%0t: tilt_about_y expected %0d actual %0d",
                             $time, want.tilt_y, got.tilt_y);
                    n_err++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        n_sent         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phase(0, 0, 300);
        test_random_phase(70, 0, 250);
        test_random_phase(0, 70, 250);
        test_random_phase(20, 20, 300);
        test_backpressure();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d samples, checked %0d angle pairs across idle and stall phases",
                 n_sent, n_got);
        if (n_err == 0 && angles_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
